// File: rtl/core/ines_pkg.sv
// Shared types and constants for the indentation nesting event stack.
`timescale 1ns / 1ps

package ines_pkg;

    localparam int MAX_DEPTH_DEF = 32;
    localparam int LINE_BITS_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int INDENT_W = 5;

    localparam logic [CMD_W-1:0] CMD_LINE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BLANK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

    localparam logic KIND_OPEN  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_DRAIN
    } ines_state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ines_shift_t;

    typedef struct packed {
        logic top_valid;
        logic next_valid;
        logic full;
    } ines_status_t;

endpackage

// File: rtl/core/ines_in_if.sv
// Input channel: one beat per source line, and one for end of document.
`timescale 1ns / 1ps

interface ines_in_if;

    logic                          valid;
    logic                          ready;
    logic [ines_pkg::CMD_W-1:0]    cmd;
    logic [ines_pkg::INDENT_W-1:0] indent;

    modport source (output valid, output cmd, output indent, input ready);
    modport sink   (input valid, input cmd, input indent, output ready);

endinterface

// File: rtl/core/ines_out_if.sv
// Output channel: one beat per open or close event.
`timescale 1ns / 1ps

interface ines_out_if #(
    parameter int LINE_BITS = ines_pkg::LINE_BITS_DEF
);

    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [LINE_BITS-1:0] event_line;
    logic                 last;

    modport source (output valid, output kind, output event_line, output last, input ready);
    modport sink   (input valid, input kind, input event_line, input last, output ready);

endinterface

// File: rtl/core/ines_cell.sv
// One stack cell: holds an entry and shifts with its neighbors on push or pop.
`timescale 1ns / 1ps

module ines_cell #(
    parameter int LINE_BITS = ines_pkg::LINE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ines_pkg::ines_shift_t         shift,
    input  logic                          up_valid,
    input  logic [ines_pkg::INDENT_W-1:0] up_indent,
    input  logic [LINE_BITS-1:0]          up_line,
    input  logic                          dn_valid,
    input  logic [ines_pkg::INDENT_W-1:0] dn_indent,
    input  logic [LINE_BITS-1:0]          dn_line,
    output logic                          valid,
    output logic [ines_pkg::INDENT_W-1:0] indent,
    output logic [LINE_BITS-1:0]          line
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [ines_pkg::INDENT_W-1:0] indent_reg;
    logic [ines_pkg::INDENT_W-1:0] indent_next;
    logic [LINE_BITS-1:0]          line_reg;
    logic [LINE_BITS-1:0]          line_next;

    always_comb
    begin
        valid_next  = valid_reg;
        indent_next = indent_reg;
        line_next   = line_reg;
        if (shift.push)
        begin
            valid_next  = up_valid;
            indent_next = up_indent;
            line_next   = up_line;
        end
        else if (shift.pop)
        begin
            valid_next  = dn_valid;
            indent_next = dn_indent;
            line_next   = dn_line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        indent_reg <= indent_next;
        line_reg   <= line_next;
    end

    assign valid  = valid_reg;
    assign indent = indent_reg;
    assign line   = line_reg;

endmodule

// File: rtl/core/ines_chain.sv
// Row of stack cells, top of stack in cell zero.
`timescale 1ns / 1ps

module ines_chain #(
    parameter int MAX_DEPTH = ines_pkg::MAX_DEPTH_DEF,
    parameter int LINE_BITS = ines_pkg::LINE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ines_pkg::ines_shift_t         shift,
    input  logic [ines_pkg::INDENT_W-1:0] push_indent,
    input  logic [LINE_BITS-1:0]          push_line,
    output ines_pkg::ines_status_t        status,
    output logic [ines_pkg::INDENT_W-1:0] top_indent,
    output logic [LINE_BITS-1:0]          top_line
);

    logic                          cell_valid  [MAX_DEPTH];
    logic [ines_pkg::INDENT_W-1:0] cell_indent [MAX_DEPTH];
    logic [LINE_BITS-1:0]          cell_line   [MAX_DEPTH];

    for (genvar i = 0; i < MAX_DEPTH; i++)
    begin : g_cell
        logic                          up_valid;
        logic [ines_pkg::INDENT_W-1:0] up_indent;
        logic [LINE_BITS-1:0]          up_line;
        logic                          dn_valid;
        logic [ines_pkg::INDENT_W-1:0] dn_indent;
        logic [LINE_BITS-1:0]          dn_line;

        if (i == 0)
        begin : g_head
            assign up_valid  = 1'b1;
            assign up_indent = push_indent;
            assign up_line   = push_line;
        end
        else
        begin : g_body
            assign up_valid  = cell_valid[i-1];
            assign up_indent = cell_indent[i-1];
            assign up_line   = cell_line[i-1];
        end

        if (i == MAX_DEPTH - 1)
        begin : g_tail
            assign dn_valid  = 1'b0;
            assign dn_indent = cell_indent[i];
            assign dn_line   = cell_line[i];
        end
        else
        begin : g_link
            assign dn_valid  = cell_valid[i+1];
            assign dn_indent = cell_indent[i+1];
            assign dn_line   = cell_line[i+1];
        end

        ines_cell #(
            .LINE_BITS (LINE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (shift),
            .up_valid  (up_valid),
            .up_indent (up_indent),
            .up_line   (up_line),
            .dn_valid  (dn_valid),
            .dn_indent (dn_indent),
            .dn_line   (dn_line),
            .valid     (cell_valid[i]),
            .indent    (cell_indent[i]),
            .line      (cell_line[i])
        );
    end

    assign status.top_valid  = cell_valid[0];
    assign status.next_valid = cell_valid[1];
    assign status.full       = cell_valid[MAX_DEPTH-1];
    assign top_indent        = cell_indent[0];
    assign top_line          = cell_line[0];

endmodule

// File: rtl/core/indent_nesting_event_stack.sv
// Top level: line sequencer, event output register and the stack cell row.
// An indented line first emits a close event for each stacked entry that it closes, then its
// open event; a blank line only advances the line counter; end of document closes every entry.
// One entry pops per cycle through the cell row while the event slot is free; the event
// register holds one beat. After a line is accepted, ST_CLOSE loads its first event there.
// Reset empties the stack and zeroes the line counter at once; no clearing pass.
`timescale 1ns / 1ps

module indent_nesting_event_stack #(
    parameter int MAX_DEPTH = ines_pkg::MAX_DEPTH_DEF,
    parameter int LINE_BITS = ines_pkg::LINE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ines_in_if.sink      line_in,
    ines_out_if.source   event_out
);

    ines_pkg::ines_state_t         state_reg;
    ines_pkg::ines_state_t         state_next;
    logic [LINE_BITS-1:0]          count_reg;
    logic [LINE_BITS-1:0]          count_next;
    logic [ines_pkg::INDENT_W-1:0] ind_reg;
    logic [ines_pkg::INDENT_W-1:0] ind_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_kind_reg;
    logic                          out_kind_next;
    logic [LINE_BITS-1:0]          out_line_reg;
    logic [LINE_BITS-1:0]          out_line_next;
    logic                          out_last_reg;
    logic                          out_last_next;

    ines_pkg::ines_shift_t         shift;
    ines_pkg::ines_status_t        status;
    logic [ines_pkg::INDENT_W-1:0] top_indent;
    logic [LINE_BITS-1:0]          top_line;

    logic                          accept;
    logic                          slot_free;
    logic                          pop_cond;
    logic                          emit;
    logic                          emit_kind;
    logic [LINE_BITS-1:0]          emit_line;
    logic                          emit_last;
    logic [LINE_BITS-1:0]          count_inc;

    assign accept    = line_in.valid && line_in.ready;
    assign slot_free = !out_valid_reg || event_out.ready;
    assign pop_cond  = status.top_valid && ((top_indent >= ind_reg) || status.full);
    assign count_inc = (count_reg == {LINE_BITS{1'b1}}) ? count_reg
                                                        : count_reg + {{(LINE_BITS-1){1'b0}}, 1'b1};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ines_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (line_in.cmd)
                        ines_pkg::CMD_LINE: state_next = ines_pkg::ST_CLOSE;
                        ines_pkg::CMD_END:  state_next = ines_pkg::ST_DRAIN;
                        default:            state_next = ines_pkg::ST_IDLE;
                    endcase
                end
            end
            ines_pkg::ST_CLOSE:
            begin
                if (slot_free && !pop_cond)
                begin
                    state_next = ines_pkg::ST_IDLE;
                end
            end
            ines_pkg::ST_DRAIN:
            begin
                if (!status.top_valid || (slot_free && !status.next_valid))
                begin
                    state_next = ines_pkg::ST_IDLE;
                end
            end
            default: state_next = ines_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        emit       = 1'b0;
        emit_kind  = ines_pkg::KIND_CLOSE;
        emit_line  = top_line;
        emit_last  = 1'b0;
        shift.push = 1'b0;
        shift.pop  = 1'b0;
        count_next = count_reg;
        ind_next   = ind_reg;
        unique case (state_reg)
            ines_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (line_in.cmd)
                        ines_pkg::CMD_LINE:
                        begin
                            count_next = count_inc;
                            ind_next   = line_in.indent;
                        end
                        ines_pkg::CMD_BLANK: count_next = count_inc;
                        ines_pkg::CMD_END:   count_next = '0;
                        default:             count_next = count_reg;
                    endcase
                end
            end
            ines_pkg::ST_CLOSE:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (pop_cond)
                    begin
                        shift.pop = 1'b1;
                    end
                    else
                    begin
                        emit_kind  = ines_pkg::KIND_OPEN;
                        emit_line  = count_reg;
                        emit_last  = 1'b1;
                        shift.push = 1'b1;
                    end
                end
            end
            ines_pkg::ST_DRAIN:
            begin
                if (slot_free && status.top_valid)
                begin
                    emit      = 1'b1;
                    emit_last = !status.next_valid;
                    shift.pop = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_line_next  = out_line_reg;
        out_last_next  = out_last_reg;
        if (slot_free)
        begin
            out_valid_next = emit;
            out_kind_next  = emit_kind;
            out_line_next  = emit_line;
            out_last_next  = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ines_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ind_reg      <= ind_next;
        out_kind_reg <= out_kind_next;
        out_line_reg <= out_line_next;
        out_last_reg <= out_last_next;
    end

    ines_chain #(
        .MAX_DEPTH (MAX_DEPTH),
        .LINE_BITS (LINE_BITS)
    ) u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift       (shift),
        .push_indent (ind_reg),
        .push_line   (count_reg),
        .status      (status),
        .top_indent  (top_indent),
        .top_line    (top_line)
    );

    assign line_in.ready         = (state_reg == ines_pkg::ST_IDLE);
    assign event_out.valid       = out_valid_reg;
    assign event_out.kind        = out_kind_reg;
    assign event_out.event_line  = out_line_reg;
    assign event_out.last        = out_last_reg;

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        shift.push |-> !status.full)
        else $error("push into a full stack");

    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        shift.pop |-> (status.top_valid && !shift.push))
        else $error("pop from an empty stack");

    a_open_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (emit_kind == ines_pkg::KIND_OPEN)) |-> emit_last)
        else $error("open event not marked last");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ines_pkg::ST_DRAIN) && (state_next == ines_pkg::ST_IDLE))
        |=> !status.top_valid)
        else $error("stack not empty after end of document");

endmodule
